// ===== src/kmeans_lloyd_clustering_top_assert.svh =====
// Assertion macros shared by the clustering block.
`ifndef KMEANS_LLOYD_CLUSTERING_TOP_ASSERT_SVH
`define KMEANS_LLOYD_CLUSTERING_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define KML_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define KML_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/kml_pkg.sv =====
package kml_pkg;

   // Default sizes
   localparam int MAX_POINTS_DEF   = 256;
   localparam int NUM_CLUSTERS_DEF = 5;

   // Point and result field widths
   localparam int FEAT_W     = 16;
   localparam int NUM_FEAT   = 4;
   localparam int CI_W       = 3;
   localparam int MC_W       = 9;
   localparam int RND_W      = 8;
   localparam int LIMIT_W    = 8;
   localparam int SQ_W       = 2 * FEAT_W;
   localparam int DIST_W     = SQ_W + 2;
   localparam int REQ_DATA_W = NUM_FEAT * FEAT_W;
   localparam int RSP_BITS   = CI_W + NUM_FEAT * FEAT_W + MC_W + RND_W + 2;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd255;

   // Sequencer states
   localparam int STATE_W = 4;
   typedef logic [STATE_W-1:0] state_type;
   localparam state_type S_LOAD   = 4'd0;
   localparam state_type S_INIT   = 4'd1;
   localparam state_type S_RSTART = 4'd2;
   localparam state_type S_RD     = 4'd3;
   localparam state_type S_DIST   = 4'd4;
   localparam state_type S_LAST   = 4'd5;
   localparam state_type S_ACC    = 4'd6;
   localparam state_type S_UPD    = 4'd7;
   localparam state_type S_DIV    = 4'd8;
   localparam state_type S_OUT    = 4'd9;
   localparam state_type S_WAITO  = 4'd10;

endpackage

// ===== src/kmeans_lloyd_clustering_top.sv =====
// Lloyd k-means over four-feature Q8.8 points. Points stream in at one item per
// cycle while the input is open, into a point memory with one write and one read
// port; extra points past MAX_POINTS are dropped and flagged. The item with tlast
// starts clustering and the input stalls until all NUM_CLUSTERS centroid items
// have been taken. Each round reads every stored point once and runs one 16x16
// squarer over the clusters and features, then updates each coordinate of each
// non-empty cluster through a shared restoring divider. A run seeds the centroids,
// then runs rounds until settled or at the limit, then sends one result per
// cluster. The point memory is never cleared; only loaded entries are used.
`include "kmeans_lloyd_clustering_top_assert.svh"
module kmeans_lloyd_clustering_top #(
   parameter int MAX_POINTS   = kml_pkg::MAX_POINTS_DEF,
   parameter int NUM_CLUSTERS = kml_pkg::NUM_CLUSTERS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // feature_a, feature_b, feature_c, feature_d
   input  logic [kml_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cluster_index, mean_a, mean_b, mean_c, mean_d, member_count, rounds_used,
   // converged, overflowed, zero pad
   output logic [kml_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [kml_pkg::LIMIT_W-1:0]     csr_wdata
);
   import kml_pkg::*;

   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CNTW = $clog2(MAX_POINTS + 1);
   localparam int CW   = $clog2(NUM_CLUSTERS);
   localparam int IW   = $clog2(NUM_CLUSTERS + 1);
   localparam int SW   = FEAT_W + CNTW;

   // Point memory and per-cluster storage
   logic [REQ_DATA_W-1:0] point_mem [MAX_POINTS];
   logic [REQ_DATA_W-1:0] rdata_ff;
   logic [AW-1:0]         rd_addr;
   logic [FEAT_W-1:0]     cent_ff [NUM_CLUSTERS][NUM_FEAT];
   logic [SW-1:0]         sums_ff [NUM_CLUSTERS][NUM_FEAT];
   logic [CNTW-1:0]       cnt_ff  [NUM_CLUSTERS];

   // Control and datapath registers
   state_type           state_ff, state_in;
   logic [CNTW-1:0]     loaded_ff, loaded_in;
   logic                drop_ff, drop_in;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [RND_W-1:0]    rnd_ff, rnd_in;
   logic                conv_ff, conv_in;
   logic [IW-1:0]       init_ff, init_in;
   logic [CNTW-1:0]     n_ff, n_in;
   logic [CW-1:0]       c_ff, c_in;
   logic [1:0]          f_ff, f_in;
   logic                sq_v_ff;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic [CW-1:0]       sq_c_ff;
   logic [1:0]          sq_f_ff;
   logic [DIST_W-1:0]   acc_ff, acc_in;
   logic [DIST_W-1:0]   best_d_ff, best_d_in;
   logic [CW-1:0]       best_c_ff, best_c_in;
   logic                settled_ff, settled_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   // Divider hookup
   logic                div_start;
   logic                div_done;
   logic [SW-1:0]       div_quo;

   // Combinational helpers
   logic [FEAT_W-1:0]   p_f, m_f, diff;
   logic [DIST_W-1:0]   tot;
   logic [LIMIT_W-1:0]  lim_eff;
   logic                moved;
   logic [IW-1:0]       init_prev;
   logic                accept;

   assign req_tready = (state_ff == S_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign lim_eff    = (limit_ff == '0) ? LIMIT_W'(1) : limit_ff;
   assign init_prev  = init_ff - IW'(1);

   // Squarer operands: current point feature against the selected centroid
   assign p_f   = rdata_ff[f_ff * FEAT_W +: FEAT_W];
   assign m_f   = cent_ff[c_ff][f_ff];
   assign diff  = (p_f > m_f) ? (p_f - m_f) : (m_f - p_f);
   assign sq_in = SQ_W'(diff) * SQ_W'(diff);
   assign tot   = acc_ff + DIST_W'(sq_ff);
   assign moved = div_quo[FEAT_W-1:8] != cent_ff[c_ff][f_ff][FEAT_W-1:8];

   // Select the point memory read address
   always_comb begin
      if (state_ff == S_INIT) begin
         rd_addr = AW'(init_ff);
      end else begin
         rd_addr = n_ff[AW-1:0];
      end
   end

   kml_div #(
      .NUM_W (SW),
      .DEN_W (CNTW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sums_ff[c_ff][f_ff]),
      .den   (cnt_ff[c_ff]),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Sequencer next state
   always_comb begin
      logic round_end;
      logic settled_now;
      logic [RND_W-1:0] rnd_next;
      round_end    = 1'b0;
      settled_now  = settled_ff;
      rnd_next     = rnd_ff + RND_W'(1);
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      drop_in      = drop_ff;
      rnd_in       = rnd_ff;
      conv_in      = conv_ff;
      init_in      = init_ff;
      n_in         = n_ff;
      c_in         = c_ff;
      f_in         = f_ff;
      acc_in       = acc_ff;
      best_d_in    = best_d_ff;
      best_c_in    = best_c_ff;
      settled_in   = settled_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      div_start    = 1'b0;

      // Accumulate distance and track the nearest cluster
      if (sq_v_ff) begin
         if (sq_f_ff == 2'd3) begin
            acc_in = '0;
            if (sq_c_ff == '0 || tot < best_d_ff) begin
               best_d_in = tot;
               best_c_in = sq_c_ff;
            end
         end else begin
            acc_in = tot;
         end
      end

      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (loaded_ff < CNTW'(MAX_POINTS)) begin
                  loaded_in = loaded_ff + CNTW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = S_INIT;
                  init_in  = '0;
                  rnd_in   = '0;
               end
            end
         end
         S_INIT: begin
            init_in = init_ff + IW'(1);
            if (init_ff == IW'(NUM_CLUSTERS)) begin
               state_in = S_RSTART;
            end
         end
         S_RSTART: begin
            n_in       = '0;
            c_in       = '0;
            f_in       = '0;
            acc_in     = '0;
            settled_in = 1'b1;
            if (loaded_ff == '0) begin
               state_in = S_UPD;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            c_in     = '0;
            f_in     = '0;
            state_in = S_DIST;
         end
         S_DIST: begin
            f_in = f_ff + 2'd1;
            if (f_ff == 2'd3) begin
               c_in = c_ff + CW'(1);
               if (c_ff == CW'(NUM_CLUSTERS - 1)) begin
                  state_in = S_LAST;
               end
            end
         end
         S_LAST: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            n_in = n_ff + CNTW'(1);
            if (n_ff + CNTW'(1) == loaded_ff) begin
               state_in = S_UPD;
               c_in     = '0;
               f_in     = '0;
            end else begin
               state_in = S_RD;
            end
         end
         S_UPD: begin
            if (cnt_ff[c_ff] == '0) begin
               f_in = '0;
               c_in = c_ff + CW'(1);
               if (c_ff == CW'(NUM_CLUSTERS - 1)) begin
                  round_end = 1'b1;
               end
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               settled_now = settled_ff && !moved;
               settled_in  = settled_now;
               f_in        = f_ff + 2'd1;
               state_in    = S_UPD;
               if (f_ff == 2'd3) begin
                  c_in = c_ff + CW'(1);
                  if (c_ff == CW'(NUM_CLUSTERS - 1)) begin
                     round_end = 1'b1;
                  end
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = (c_ff == CW'(NUM_CLUSTERS - 1));
               rsp_data_in  = RSP_DATA_W'({drop_ff, conv_ff, rnd_ff,
                                          MC_W'(cnt_ff[c_ff]),
                                          cent_ff[c_ff][3], cent_ff[c_ff][2],
                                          cent_ff[c_ff][1], cent_ff[c_ff][0],
                                          CI_W'(c_ff)});
               c_in = c_ff + CW'(1);
               if (c_ff == CW'(NUM_CLUSTERS - 1)) begin
                  state_in = S_WAITO;
               end
            end
         end
         S_WAITO: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               loaded_in    = '0;
               drop_in      = 1'b0;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      // Close a round: stop on settle or limit, else go again
      if (round_end) begin
         rnd_in = rnd_next;
         c_in   = '0;
         if (settled_now) begin
            conv_in  = 1'b1;
            state_in = S_OUT;
         end else if (rnd_next >= lim_eff) begin
            conv_in  = 1'b0;
            state_in = S_OUT;
         end else begin
            state_in = S_RSTART;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         loaded_ff    <= '0;
         drop_ff      <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         rnd_ff       <= '0;
         conv_ff      <= 1'b0;
         sq_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         drop_ff      <= drop_in;
         rnd_ff       <= rnd_in;
         conv_ff      <= conv_in;
         sq_v_ff      <= (state_ff == S_DIST);
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      init_ff     <= init_in;
      n_ff        <= n_in;
      c_ff        <= c_in;
      f_ff        <= f_in;
      sq_ff       <= sq_in;
      sq_c_ff     <= c_ff;
      sq_f_ff     <= f_ff;
      acc_ff      <= acc_in;
      best_d_ff   <= best_d_in;
      best_c_ff   <= best_c_in;
      settled_ff  <= settled_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Point memory: write on load, registered read
   always_ff @(posedge clock) begin
      if (accept && loaded_ff < CNTW'(MAX_POINTS)) begin
         point_mem[loaded_ff[AW-1:0]] <= req_tdata;
      end
      rdata_ff <= point_mem[rd_addr];
   end

   // Cluster storage: seed, clear, accumulate, update
   always_ff @(posedge clock) begin
      if (state_ff == S_INIT && init_ff != '0) begin
         for (int f = 0; f < NUM_FEAT; f++) begin
            cent_ff[CW'(init_prev)][f] <= (int'(init_prev) < int'(loaded_ff)) ?
                                          rdata_ff[f * FEAT_W +: FEAT_W] : '0;
         end
      end
      if (state_ff == S_RSTART) begin
         for (int c = 0; c < NUM_CLUSTERS; c++) begin
            cnt_ff[c] <= '0;
            for (int f = 0; f < NUM_FEAT; f++) begin
               sums_ff[c][f] <= '0;
            end
         end
      end
      if (state_ff == S_ACC) begin
         cnt_ff[best_c_ff] <= cnt_ff[best_c_ff] + CNTW'(1);
         for (int f = 0; f < NUM_FEAT; f++) begin
            sums_ff[best_c_ff][f] <= sums_ff[best_c_ff][f] +
                                     SW'(rdata_ff[f * FEAT_W +: FEAT_W]);
         end
      end
      if (state_ff == S_DIV && div_done) begin
         cent_ff[c_ff][f_ff] <= div_quo[FEAT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   `KML_ASSERT_IMPL(a_no_overlap, rsp_tvalid, !req_tready, "input open while results pending")
   `KML_ASSERT_NEXT(a_reopen, rsp_tvalid && rsp_tready && rsp_tlast, req_tready,
                    "input not reopened after last result")
   `KML_ASSERT_IMPL(a_fill_bound, 1'b1, loaded_ff <= CNTW'(MAX_POINTS),
                    "point count beyond memory depth")

endmodule

// ===== src/kml_div.sv =====
module kml_div #(
   parameter int NUM_W = 25,
   parameter int DEN_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   shifted;
   logic             fits;

   // Restoring division, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      fits    = shifted >= {1'b0, den};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(shifted - {1'b0, den}) : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import kml_pkg::*;

   localparam int NPTS  = 256;
   localparam int NCLU  = 5;
   localparam int CYCLE_LIMIT = 20000000;

   // Centroid item as seen on the result channel
   typedef struct packed {
      bit [2:0]       idx;
      bit [3:0][15:0] mean;
      bit [8:0]       count;
      bit [7:0]       rounds;
      bit             conv;
      bit             ovf;
      bit             last;
   } centroid_t;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [LIMIT_W-1:0]    csr_wdata;

   kmeans_lloyd_clustering_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Clustering model state
   bit [63:0]  point_mem [NPTS];
   int         n_loaded;
   bit         dropped;
   int         centroid [NCLU][4];
   int         member_cnt [NCLU];
   int         round_limit;
   centroid_t  expected_centroids [$];

   int  errors;
   int  send_idle;
   int  recv_idle;
   int  hold_left;
   int  cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // One assignment and update round; returns 1 when no integer part moved
   function automatic bit lloyd_round();
      longint unsigned sums [NCLU][4];
      longint unsigned sq_sum, best_dist, dif;
      int best, p, m, nm;
      bit settled;
      settled = 1'b1;
      for (int c = 0; c < NCLU; c++) begin
         member_cnt[c] = 0;
         for (int f = 0; f < 4; f++) sums[c][f] = 0;
      end
      for (int n = 0; n < n_loaded; n++) begin
         best = 0;
         best_dist = 0;
         for (int c = 0; c < NCLU; c++) begin
            sq_sum = 0;
            for (int f = 0; f < 4; f++) begin
               p = int'(point_mem[n][16*f +: 16]);
               m = centroid[c][f];
               dif = (p > m) ? p - m : m - p;
               sq_sum += dif * dif;
            end
            if (c == 0 || sq_sum < best_dist) begin
               best_dist = sq_sum;
               best = c;
            end
         end
         for (int f = 0; f < 4; f++) sums[best][f] += point_mem[n][16*f +: 16];
         member_cnt[best]++;
      end
      for (int c = 0; c < NCLU; c++) begin
         if (member_cnt[c] != 0) begin
            for (int f = 0; f < 4; f++) begin
               nm = int'((sums[c][f] / member_cnt[c]) & 16'hFFFF);
               if ((nm >> 8) != (centroid[c][f] >> 8)) settled = 1'b0;
               centroid[c][f] = nm;
            end
         end
      end
      return settled;
   endfunction

   // Store one accepted point; on the final point cluster and queue the centroids
   task automatic accept_point(bit [63:0] word, bit fin);
      int rounds, lim;
      bit conv;
      centroid_t r;
      if (n_loaded < NPTS) begin
         point_mem[n_loaded] = word;
         n_loaded++;
      end else begin
         dropped = 1'b1;
      end
      if (!fin) return;
      for (int c = 0; c < NCLU; c++)
         for (int f = 0; f < 4; f++)
            centroid[c][f] = (c < n_loaded) ? int'(point_mem[c][16*f +: 16]) : 0;
      lim = (round_limit == 0) ? 1 : round_limit;
      rounds = 0;
      conv = 1'b0;
      forever begin
         bit s;
         s = lloyd_round();
         rounds = (rounds + 1) & 8'hFF;
         if (s) begin
            conv = 1'b1;
            break;
         end
         if (rounds >= lim) break;
      end
      for (int c = 0; c < NCLU; c++) begin
         r.idx = 3'(c);
         for (int f = 0; f < 4; f++) r.mean[f] = 16'(centroid[c][f]);
         r.count  = 9'(member_cnt[c]);
         r.rounds = 8'(rounds);
         r.conv   = conv;
         r.ovf    = dropped;
         r.last   = (c == NCLU - 1);
         expected_centroids = {expected_centroids, r};
      end
      n_loaded = 0;
      dropped = 1'b0;
   endtask

   // Offer one point and hold it until accepted; valid stays high on return
   task automatic send_point(bit [15:0] a, bit [15:0] b, bit [15:0] c, bit [15:0] d,
                             bit fin);
      if ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {d, c, b, a};
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accept_point({d, c, b, a}, fin);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
   endtask

   // Wait until every centroid has come back, then let the block settle
   task automatic wait_drained();
      stop_sending();
      while (expected_centroids.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(int value);
      stop_sending();
      csr_we    <= 1'b1;
      csr_wdata <= LIMIT_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      round_limit = value;
   endtask

   // Send a data set: points around three random centers, or all noise when spread is set
   task automatic send_set(int n, bit spread);
      bit [15:0] ctr [3][4];
      bit [15:0] v [4];
      int k, span;
      span = $urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom_range(16, 2048);
      for (int i = 0; i < 3; i++)
         for (int f = 0; f < 4; f++) ctr[i][f] = 16'($urandom);
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 2);
         for (int f = 0; f < 4; f++) begin
            if (spread) v[f] = 16'($urandom);
            else v[f] = 16'(ctr[k][f] + $urandom_range(0, span) - span / 2);
         end
         send_point(v[0], v[1], v[2], v[3], i == n - 1);
      end
   endtask

   // Limits at both extremes and a single-point set
   task automatic test_limit_extremes();
      send_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      wait_drained();
      write_limit(1);
      send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_point(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
      send_point(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
      send_point(16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00, 1'b0);
      send_point(16'h1234, 16'hABCD, 16'h5A5A, 16'hA5A5, 1'b1);
      wait_drained();
      write_limit(255);
   endtask

   // Identical points tie toward cluster zero and leave the rest empty
   task automatic test_ties_and_empty();
      repeat (6) send_point(16'h0180, 16'h0240, 16'h0300, 16'h0400, 1'b0);
      send_point(16'h0180, 16'h0240, 16'h0300, 16'h0400, 1'b1);
      wait_drained();
      // three points along one feature, each on its own seed
      send_point(16'h0100, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_point(16'h0300, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_point(16'h0200, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      wait_drained();
   endtask

   // Fewer points than clusters: missing seeds are zero
   task automatic test_few_points();
      send_point(16'h4000, 16'h2000, 16'h1000, 16'h0800, 1'b0);
      send_point(16'h0010, 16'h0020, 16'h0030, 16'h0040, 1'b1);
      wait_drained();
   endtask

   // Overflow the point memory, the final point itself dropped
   task automatic test_memory_full();
      write_limit(2);
      send_set(NPTS + 3, 1'b0);
      wait_drained();
   endtask

   // Hold the receiver so the next data set stalls at the input
   task automatic test_backpressure();
      write_limit(8);
      send_idle = 0;
      hold_left = 40000;
      send_set(6, 1'b0);
      send_set(9, 1'b0);
      send_set(4, 1'b1);
      wait_drained();
   endtask

   task automatic test_random(int items);
      int sent, n, pick;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(0, 5);
         case (pick)
            0:       write_limit(1);
            1:       write_limit(255);
            2:       write_limit($urandom_range(2, 4));
            default: write_limit($urandom_range(1, 255));
         endcase
         n = $urandom_range(0, 7) == 0 ? $urandom_range(1, 4) : $urandom_range(5, 16);
         send_set(n, $urandom_range(0, 4) == 0);
         sent += n;
         wait_drained();
      end
   endtask

   // Receiver: long hold-off when asked, else random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $display("%0t: mismatch %s expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Compare each centroid item with the oldest expectation
   always @(posedge clock) begin
      centroid_t want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.idx    = rsp_tdata[2:0];
         got.mean   = rsp_tdata[66:3];
         got.count  = rsp_tdata[75:67];
         got.rounds = rsp_tdata[83:76];
         got.conv   = rsp_tdata[84];
         got.ovf    = rsp_tdata[85];
         got.last   = rsp_tlast;
         if (expected_centroids.size() == 0) begin
            $display("%0t: unexpected centroid item, expected none actual %0h",
                     $time, got);
            errors++;
         end else begin
            want = expected_centroids.pop_front();
            check_field("cluster_index", want.idx, got.idx);
            for (int f = 0; f < 4; f++)
               check_field($sformatf("mean[%0d]", f), want.mean[f], got.mean[f]);
            check_field("member_count", want.count, got.count);
            check_field("rounds_used", want.rounds, got.rounds);
            check_field("converged", want.conv, got.conv);
            check_field("overflowed", want.ovf, got.ovf);
            check_field("last", want.last, got.last);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      errors = 0;
      cycles = 0;
      hold_left = 0;
      send_idle = 34;
      recv_idle = 80;
      n_loaded = 0;
      dropped = 1'b0;
      round_limit = 255;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_limit_extremes();
      test_ties_and_empty();
      test_few_points();
      test_random(40);
      send_idle = 80;
      recv_idle = 34;
      test_memory_full();
      test_random(40);
      send_idle = 0;
      recv_idle = 0;
      test_random(40);
      test_backpressure();

      wait_drained();
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
